@@ rtl/tcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpg_pkg - shared types and constants of the test card pattern generator
// Field widths, register indexes, the color bar table and the small helper
// functions that turn frame sizes into segment widths and band limits.
// ----------------------------------------------------------------------------
package tcpg_pkg;

    // Upper clamp for the line width; the 10-bit width field stops at 1023
    localparam int MAX_WIDTH = 1024;

    localparam int DIM_W   = 10;   // column, row and frame size fields
    localparam int COLOR_W = 8;    // RGB332 pixel
    localparam int BAND_W  = 3;    // band number, 0..4
    localparam int SEG_W   = 5;    // segment number, 0..15
    localparam int QUOT_W  = 8;    // height / 5, at most 204
    localparam int CFG_AW  = 1;    // register index width

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [BAND_W-1:0] BAND_BARS  = 3'd0;
    localparam logic [BAND_W-1:0] BAND_BLUE  = 3'd3;
    localparam logic [BAND_W-1:0] BAND_LAST  = 3'd4;

    localparam logic [COLOR_W-1:0] BORDER_COLOR = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    // Effective frame geometry, held by the configuration block
    typedef struct packed {
        logic [DIM_W-1:0]  width;     // clamped to 16..1023
        logic [DIM_W-1:0]  height;    // clamped to at least 5
        logic [QUOT_W-1:0] band_rows; // height / 5
    } cfg_t;

    // One result item
    typedef struct packed {
        logic              frame_end;
        logic              line_end;
        logic [DIM_W-1:0]  pixel_row;
        logic [DIM_W-1:0]  pixel_column;
        logic [COLOR_W-1:0] pixel_color;
    } pix_t;

    // Clamp a written width into the drawable range
    function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
        logic [DIM_W-1:0] r;
        r = w;
        if (32'(w) > MAX_WIDTH)
            r = DIM_W'(MAX_WIDTH);
        if (r < DIM_W'(16))
            r = DIM_W'(16);
        return r;
    endfunction

    // Clamp a written height so every band has a row
    function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] h);
        logic [DIM_W-1:0] r;
        r = h;
        if (r < DIM_W'(5))
            r = DIM_W'(5);
        return r;
    endfunction

    // h / 5 as a multiply by 205/1024, exact for h below 1024
    function automatic logic [QUOT_W-1:0] div5(input logic [DIM_W-1:0] h);
        logic [DIM_W+QUOT_W-1:0] p;
        p = h * 8'd205;
        return p[DIM_W+QUOT_W-1:DIM_W];
    endfunction

    // Width of one segment in a band
    function automatic logic [DIM_W-1:0] seg_width(input logic [BAND_W-1:0] band,
                                                    input logic [DIM_W-1:0]  w);
        logic [DIM_W-1:0] r;
        case (band)
            BAND_BARS: r = w >> 4;
            BAND_BLUE: r = w >> 2;
            default:   r = w >> 3;
        endcase
        return r;
    endfunction

    // Last segment number of a band
    function automatic logic [SEG_W-1:0] seg_last(input logic [BAND_W-1:0] band);
        logic [SEG_W-1:0] r;
        case (band)
            BAND_BARS: r = 5'd15;
            BAND_BLUE: r = 5'd3;
            default:   r = 5'd7;
        endcase
        return r;
    endfunction

    // First row past a band; the last band runs to the frame bottom
    function automatic logic [DIM_W-1:0] band_end(input logic [BAND_W-1:0]  band,
                                                   input logic [DIM_W-1:0]   h,
                                                   input logic [QUOT_W-1:0]  q);
        logic [DIM_W-1:0] q1;
        logic [DIM_W-1:0] r;
        q1 = {{(DIM_W-QUOT_W){1'b0}}, q};
        case (band)
            3'd0:    r = q1;
            3'd1:    r = q1 << 1;
            3'd2:    r = (q1 << 1) + q1;
            3'd3:    r = q1 << 2;
            default: r = h;
        endcase
        return r;
    endfunction

    // Sixteen color bars
    function automatic logic [COLOR_W-1:0] bar_color(input logic [3:0] s);
        logic [COLOR_W-1:0] r;
        case (s)
            4'd0:    r = 8'h00;
            4'd1:    r = 8'h80;
            4'd2:    r = 8'h10;
            4'd3:    r = 8'h90;
            4'd4:    r = 8'h02;
            4'd5:    r = 8'h82;
            4'd6:    r = 8'h12;
            4'd7:    r = 8'hDB;
            4'd8:    r = 8'h92;
            4'd9:    r = 8'hE0;
            4'd10:   r = 8'h1C;
            4'd11:   r = 8'hFC;
            4'd12:   r = 8'h03;
            4'd13:   r = 8'hE3;
            4'd14:   r = 8'h1F;
            default: r = 8'hFF;
        endcase
        return r;
    endfunction

    // Color of a segment inside a band
    function automatic logic [COLOR_W-1:0] band_color(input logic [BAND_W-1:0] band,
                                                       input logic [SEG_W-1:0]  s);
        logic [COLOR_W-1:0] r;
        case (band)
            3'd0:    r = bar_color(s[3:0]);
            3'd1:    r = {s[2:0], 5'b0};
            3'd2:    r = {1'b0, s, 2'b0};
            3'd3:    r = {3'b0, s};
            default: r = {s[2:0], 5'b0} | {1'b0, s, 2'b0} | {4'b0, s[4:1]};
        endcase
        return r;
    endfunction

    // Geometry after reset
    localparam logic [DIM_W-1:0]  RESET_WIDTH  = eff_width(DIM_W'(640));
    localparam logic [DIM_W-1:0]  RESET_HEIGHT = eff_height(DIM_W'(480));
    localparam logic [QUOT_W-1:0] RESET_QUOT   = div5(RESET_HEIGHT);

endpackage

@@ rtl/tcpg_cfg.sv @@
// ----------------------------------------------------------------------------
// tcpg_cfg - frame geometry registers
// Clamps written sizes and keeps height / 5 ready for the band counters.
// ----------------------------------------------------------------------------
module tcpg_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tcpg_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [tcpg_pkg::DIM_W-1:0]    cfg_wdata,
    output tcpg_pkg::cfg_t                cfg
);

    logic [tcpg_pkg::DIM_W-1:0]  width_reg;
    logic [tcpg_pkg::DIM_W-1:0]  height_reg;
    logic [tcpg_pkg::QUOT_W-1:0] quot_reg;
    logic [tcpg_pkg::DIM_W-1:0]  height_next;

    assign height_next = tcpg_pkg::eff_height(cfg_wdata);

    // Capture clamped sizes on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tcpg_pkg::RESET_WIDTH;
            height_reg <= tcpg_pkg::RESET_HEIGHT;
            quot_reg   <= tcpg_pkg::RESET_QUOT;
        end
        else if (cfg_we)
        begin
            case (tcpg_pkg::reg_idx_t'(cfg_addr))
                tcpg_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg <= tcpg_pkg::eff_width(cfg_wdata);
                end
                tcpg_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg <= height_next;
                    quot_reg   <= tcpg_pkg::div5(height_next);
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    assign cfg.width     = width_reg;
    assign cfg.height    = height_reg;
    assign cfg.band_rows = quot_reg;

endmodule

@@ rtl/tcpg_core.sv @@
// ----------------------------------------------------------------------------
// tcpg_core - raster position and color of the next pixel
// Holds column, row, band and segment counters; one item advances them by
// one pixel and yields the pixel's color, position and end marks.
// ----------------------------------------------------------------------------
module tcpg_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  tcpg_pkg::cfg_t   cfg,
    input  logic             advance,
    input  logic             restart,
    output tcpg_pkg::pix_t   pix
);

    logic [tcpg_pkg::DIM_W-1:0]  col_reg,  col_next;
    logic [tcpg_pkg::DIM_W-1:0]  row_reg,  row_next;
    logic [tcpg_pkg::BAND_W-1:0] band_reg, band_next;
    logic [tcpg_pkg::DIM_W-1:0]  ber_reg,  ber_next;
    logic [tcpg_pkg::SEG_W-1:0]  seg_reg,  seg_next;
    logic [tcpg_pkg::DIM_W-1:0]  sl_reg,   sl_next;

    logic [tcpg_pkg::DIM_W-1:0]  col_cur, row_cur, ber_cur, sl_cur, row_inc;
    logic [tcpg_pkg::BAND_W-1:0] band_cur, band_inc;
    logic [tcpg_pkg::SEG_W-1:0]  seg_cur;
    logic [tcpg_pkg::DIM_W-1:0]  col_last, row_last, first_seg_w;
    logic                        lend, fend, border;

    assign col_last    = cfg.width - 10'd1;
    assign row_last    = cfg.height - 10'd1;
    assign first_seg_w = tcpg_pkg::seg_width(tcpg_pkg::BAND_BARS, cfg.width);

    // Restart jumps to the top-left pixel before drawing
    always_comb
    begin
        col_cur  = restart ? '0 : col_reg;
        row_cur  = restart ? '0 : row_reg;
        band_cur = restart ? tcpg_pkg::BAND_BARS : band_reg;
        ber_cur  = restart ? {2'b0, cfg.band_rows} : ber_reg;
        seg_cur  = restart ? '0 : seg_reg;
        sl_cur   = restart ? first_seg_w : sl_reg;
    end

    // Draw the pixel
    always_comb
    begin
        lend   = col_cur >= col_last;
        fend   = lend && (row_cur >= row_last);
        border = (col_cur == '0) || lend || (row_cur == '0) || (row_cur >= row_last);
        pix.pixel_color  = border ? tcpg_pkg::BORDER_COLOR
                                  : tcpg_pkg::band_color(band_cur, seg_cur);
        pix.pixel_column = col_cur;
        pix.pixel_row    = row_cur;
        pix.line_end     = lend;
        pix.frame_end    = fend;
    end

    assign row_inc  = row_cur + 10'd1;
    assign band_inc = band_cur + 3'd1;

    // Advance the raster counters
    always_comb
    begin
        col_next  = col_cur + 10'd1;
        row_next  = row_cur;
        band_next = band_cur;
        ber_next  = ber_cur;
        seg_next  = seg_cur;
        sl_next   = sl_cur - 10'd1;
        if (fend)
        begin
            col_next  = '0;
            row_next  = '0;
            band_next = tcpg_pkg::BAND_BARS;
            ber_next  = {2'b0, cfg.band_rows};
            seg_next  = '0;
            sl_next   = first_seg_w;
        end
        else if (lend)
        begin
            col_next = '0;
            row_next = row_inc;
            seg_next = '0;
            if ((band_cur < tcpg_pkg::BAND_LAST) && (row_inc >= ber_cur))
            begin
                band_next = band_inc;
                ber_next  = tcpg_pkg::band_end(band_inc, cfg.height, cfg.band_rows);
                sl_next   = tcpg_pkg::seg_width(band_inc, cfg.width);
            end
            else
            begin
                sl_next = tcpg_pkg::seg_width(band_cur, cfg.width);
            end
        end
        else if (sl_cur <= 10'd1)
        begin
            sl_next = tcpg_pkg::seg_width(band_cur, cfg.width);
            if (seg_cur < tcpg_pkg::seg_last(band_cur))
                seg_next = seg_cur + 5'd1;
        end
    end

    // Hold the counters until an item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            band_reg <= tcpg_pkg::BAND_BARS;
            ber_reg  <= {2'b0, tcpg_pkg::RESET_QUOT};
            seg_reg  <= '0;
            sl_reg   <= tcpg_pkg::seg_width(tcpg_pkg::BAND_BARS, tcpg_pkg::RESET_WIDTH);
        end
        else if (advance)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            band_reg <= band_next;
            ber_reg  <= ber_next;
            seg_reg  <= seg_next;
            sl_reg   <= sl_next;
        end
    end

    // Band number never passes the gray ramp
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        band_reg <= tcpg_pkg::BAND_LAST)
        else $error("band counter out of range");

    // Segment countdown is reloaded before it reaches zero
    a_seg_left: assert property (@(posedge clk) disable iff (!rst_n)
        sl_reg != '0)
        else $error("segment countdown reached zero");

    // A line end returns the column to zero
    a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && lend) |=> (col_reg == '0))
        else $error("column did not wrap after line end");

    // A frame end returns to the top band
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fend) |=> (row_reg == '0 && band_reg == tcpg_pkg::BAND_BARS))
        else $error("frame did not restart after frame end");

endmodule

@@ rtl/tcpg_out.sv @@
// ----------------------------------------------------------------------------
// tcpg_out - result register of the pixel stream
// Holds one pixel for the receiver and takes the next in the same cycle
// the held one leaves.
// ----------------------------------------------------------------------------
module tcpg_out
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tcpg_pkg::pix_t                      pix,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tcpg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser
);

    logic           valid_reg;
    tcpg_pkg::pix_t pix_reg;

    assign in_ready = !valid_reg || m_axis_tready;

    // Track whether a pixel is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Load the next pixel whenever the slot frees up
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pix_reg <= pix;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0, pix_reg.pixel_row, pix_reg.pixel_column,
                            pix_reg.pixel_color};
    assign m_axis_tlast  = pix_reg.line_end;
    assign m_axis_tuser  = pix_reg.frame_end;

endmodule

@@ rtl/test_card_pattern_generator_unit.sv @@
// ----------------------------------------------------------------------------
// test_card_pattern_generator_unit - RGB332 test card pixel source
// Each input item produces the next pixel of a five-band test card with a
// white border, in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per pixel; tdata[0] = restart (1 = go to top-left pixel).
//   m_axis: one item per input item; tdata = color, column, row; tlast marks
//           the last pixel of a line, tuser the last pixel of the frame.
//   cfg:    cfg_we with cfg_addr 0 writes frame_width, 1 writes frame_height;
//           write only while the stream is idle.
// An accepted item is held in the output register from the cycle after it is
// accepted. Throughput is one item per cycle while the receiver keeps up, set
// by the single counter update between the state and output registers.
// Reset selects a 640 x 480 frame and puts the raster at the top-left pixel.
// When the receiver stalls, one pixel is held in the output register and
// s_axis_tready drops until it is taken; no item is lost or repeated.
// ----------------------------------------------------------------------------
module test_card_pattern_generator_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tcpg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] restart
    // Result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] pixel_color, [17:8] pixel_column, [27:18] pixel_row
    output logic [tcpg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,  // line_end
    output logic                                m_axis_tuser,  // frame_end
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [tcpg_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [tcpg_pkg::DIM_W-1:0]          cfg_wdata
);

    tcpg_pkg::cfg_t cfg;
    tcpg_pkg::pix_t pix;
    logic           ready;
    logic           advance;

    assign s_axis_tready = ready;
    assign advance       = s_axis_tvalid && ready;

    tcpg_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tcpg_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .restart (s_axis_tdata[0]),
        .pix     (pix)
    );

    tcpg_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (ready),
        .pix           (pix),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the test card pattern generator
// Streams restart/advance items into the block and predicts every pixel
// (color, column, row, line and frame marks) with its own raster walker.
// Frame sizes change between phases, mostly small so that lines, bands and
// frames complete often; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // Ramp bands that the package leaves unnamed
    localparam logic [tcpg_pkg::BAND_W-1:0] BAND_RED   = 3'd1;
    localparam logic [tcpg_pkg::BAND_W-1:0] BAND_GREEN = 3'd2;

    localparam logic [tcpg_pkg::COLOR_W-1:0] BAR_TABLE [16] = '{
        8'h00, 8'h80, 8'h10, 8'h90, 8'h02, 8'h82, 8'h12, 8'hDB,
        8'h92, 8'hE0, 8'h1C, 8'hFC, 8'h03, 8'hE3, 8'h1F, 8'hFF
    };

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [tcpg_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_tready = 1'b0;
    logic [tcpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             m_axis_tuser;
    logic                             cfg_we = 1'b0;
    logic [tcpg_pkg::CFG_AW-1:0]      cfg_addr = '0;
    logic [tcpg_pkg::DIM_W-1:0]       cfg_wdata = '0;

    // Pending restart flags and the pixels they must produce
    bit             restart_q [$];
    tcpg_pkg::pix_t pixel_q [$];

    int src_idle_pct = 38;
    int sink_idle_pct = 71;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int err_count = 0;
    int cycle_cnt = 0;

    // Raster walker state and register copies
    logic [tcpg_pkg::DIM_W-1:0]  reg_width;
    logic [tcpg_pkg::DIM_W-1:0]  reg_height;
    logic [tcpg_pkg::DIM_W-1:0]  col_cnt;
    logic [tcpg_pkg::DIM_W-1:0]  row_cnt;
    logic [tcpg_pkg::BAND_W-1:0] band_r;
    logic [tcpg_pkg::DIM_W-1:0]  band_end_r;
    logic [tcpg_pkg::SEG_W-1:0]  seg_r;
    logic [tcpg_pkg::DIM_W-1:0]  seg_left_r;

    test_card_pattern_generator_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Clamp the written sizes the way the block draws them
    function automatic int width_now();
        int w;
        w = reg_width;
        if (w > tcpg_pkg::MAX_WIDTH)
            w = tcpg_pkg::MAX_WIDTH;
        if (w < 16)
            w = 16;
        return w;
    endfunction

    function automatic int height_now();
        int h;
        h = reg_height;
        if (h < 5)
            h = 5;
        return h;
    endfunction

    function automatic int seg_pixels(input logic [tcpg_pkg::BAND_W-1:0] band);
        if (band == tcpg_pkg::BAND_BARS)
            return width_now() / 16;
        if (band == tcpg_pkg::BAND_BLUE)
            return width_now() / 4;
        return width_now() / 8;
    endfunction

    function automatic int seg_top(input logic [tcpg_pkg::BAND_W-1:0] band);
        if (band == tcpg_pkg::BAND_BARS)
            return 15;
        if (band == tcpg_pkg::BAND_BLUE)
            return 3;
        return 7;
    endfunction

    function automatic int band_limit(input logic [tcpg_pkg::BAND_W-1:0] band);
        if (band >= tcpg_pkg::BAND_LAST)
            return height_now();
        return (band + 1) * (height_now() / 5);
    endfunction

    // Go back to the top-left pixel with the current sizes
    function automatic void home_raster();
        col_cnt    = '0;
        row_cnt    = '0;
        band_r     = tcpg_pkg::BAND_BARS;
        band_end_r = tcpg_pkg::DIM_W'(band_limit(tcpg_pkg::BAND_BARS));
        seg_r      = '0;
        seg_left_r = tcpg_pkg::DIM_W'(seg_pixels(tcpg_pkg::BAND_BARS));
    endfunction

    function automatic logic [tcpg_pkg::COLOR_W-1:0] segment_color();
        int s;
        s = seg_r;
        case (band_r)
            tcpg_pkg::BAND_BARS: return BAR_TABLE[s & 15];
            BAND_RED:   return tcpg_pkg::COLOR_W'((s << 5) & 255);
            BAND_GREEN: return tcpg_pkg::COLOR_W'((s << 2) & 255);
            tcpg_pkg::BAND_BLUE: return tcpg_pkg::COLOR_W'(s & 255);
            default:
                return tcpg_pkg::COLOR_W'(((s << 5) | (s << 2) | (s >> 1)) & 255);
        endcase
    endfunction

    // Emit the pixel for one item and advance the raster
    function automatic tcpg_pkg::pix_t raster_step(input logic restart);
        int             w;
        int             h;
        logic           lend;
        logic           fend;
        tcpg_pkg::pix_t p;
        w = width_now();
        h = height_now();
        if (restart)
            home_raster();
        lend = (col_cnt >= w - 1);
        fend = lend && (row_cnt >= h - 1);
        if (col_cnt == 0 || col_cnt >= w - 1 || row_cnt == 0 || row_cnt >= h - 1)
            p.pixel_color = tcpg_pkg::BORDER_COLOR;
        else
            p.pixel_color = segment_color();
        p.pixel_column = col_cnt;
        p.pixel_row    = row_cnt;
        p.line_end     = lend;
        p.frame_end    = fend;
        if (fend)
            home_raster();
        else if (lend)
        begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
            if (band_r < tcpg_pkg::BAND_LAST && row_cnt >= band_end_r)
            begin
                band_r     = band_r + 1'b1;
                band_end_r = tcpg_pkg::DIM_W'(band_limit(band_r));
            end
            seg_r      = '0;
            seg_left_r = tcpg_pkg::DIM_W'(seg_pixels(band_r));
        end
        else
        begin
            col_cnt = col_cnt + 1'b1;
            if (seg_left_r <= 1)
            begin
                seg_left_r = tcpg_pkg::DIM_W'(seg_pixels(band_r));
                if (seg_r < seg_top(band_r))
                    seg_r = seg_r + 1'b1;
            end
            else
                seg_left_r = seg_left_r - 1'b1;
        end
        return p;
    endfunction

    // Feed pending items; predict each one as it is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_axis_tready)
                pixel_q.push_back(raster_step(s_tdata[0]));
            if (!s_tvalid || s_axis_tready)
            begin
                if (restart_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    s_tdata  <= {{(tcpg_pkg::IN_TDATA_W-1){1'b0}}, restart_q.pop_front()};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Drive receiver ready; count out a long hold when one is asked for
    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Check each accepted pixel against the oldest prediction
    always @(posedge clk)
    begin : monitor
        tcpg_pkg::pix_t got;
        tcpg_pkg::pix_t want;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            got.pixel_color  = m_axis_tdata[7:0];
            got.pixel_column = m_axis_tdata[17:8];
            got.pixel_row    = m_axis_tdata[27:18];
            got.line_end     = m_axis_tlast;
            got.frame_end    = m_axis_tuser;
            if (pixel_q.size() == 0)
            begin
                err_count <= err_count + 1;
                if (err_count < 10)
                    $display("unexpected pixel: color %02h col %0d row %0d",
                             got.pixel_color, got.pixel_column, got.pixel_row);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (got.pixel_color !== want.pixel_color ||
                    got.pixel_column !== want.pixel_column ||
                    got.pixel_row !== want.pixel_row ||
                    got.line_end !== want.line_end ||
                    got.frame_end !== want.frame_end)
                begin
                    err_count <= err_count + 1;
                    if (err_count < 10)
                        $display("pixel mismatch: exp color %02h col %0d row %0d",
                                 want.pixel_color, want.pixel_column, want.pixel_row,
                                 " le %0b fe %0b,", want.line_end, want.frame_end,
                                 " got color %02h col %0d row %0d",
                                 got.pixel_color, got.pixel_column, got.pixel_row,
                                 " le %0b fe %0b", got.line_end, got.frame_end);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input tcpg_pkg::reg_idx_t idx,
                             input logic [tcpg_pkg::DIM_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tcpg_pkg::REG_FRAME_WIDTH)
            reg_width = val;
        else
            reg_height = val;
    endtask

    // Wait until every item is taken and every pixel has come back
    task automatic drain();
        while (restart_q.size() != 0 || s_tvalid || pixel_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly tiny frames so lines, bands and frames finish often
    function automatic logic [tcpg_pkg::DIM_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return tcpg_pkg::DIM_W'($urandom_range(16, 21));
        if (r < 88)
            return tcpg_pkg::DIM_W'($urandom_range(0, 15));
        return tcpg_pkg::DIM_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [tcpg_pkg::DIM_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return tcpg_pkg::DIM_W'($urandom_range(5, 7));
        if (r < 88)
            return tcpg_pkg::DIM_W'($urandom_range(0, 4));
        return tcpg_pkg::DIM_W'($urandom_range(0, 1023));
    endfunction

    initial
    begin : stimulus
        int ph;
        int n;
        reg_width  = 10'd640;
        reg_height = 10'd480;
        home_raster();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: advance, then restart
        restart_q.push_back(1'b0);
        restart_q.push_back(1'b0);
        restart_q.push_back(1'b1);
        drain();

        // Sizes below the minimum: run one full clamped line
        write_reg(tcpg_pkg::REG_FRAME_WIDTH, 10'd0);
        write_reg(tcpg_pkg::REG_FRAME_HEIGHT, 10'd0);
        restart_q.push_back(1'b1);
        for (n = 0; n < 16; n++)
            restart_q.push_back(1'b0);
        drain();

        // Largest sizes
        write_reg(tcpg_pkg::REG_FRAME_WIDTH, 10'd1023);
        write_reg(tcpg_pkg::REG_FRAME_HEIGHT, 10'd1023);
        restart_q.push_back(1'b1);
        for (n = 0; n < 3; n++)
            restart_q.push_back(1'b0);
        drain();

        // Random phases; the raster carries over size changes unless restarted
        for (ph = 0; ph < 10; ph++)
        begin
            if (ph == 3)
            begin
                src_idle_pct  = 71;
                sink_idle_pct = 38;
            end
            if (ph == 6)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (ph == 0 || $urandom_range(0, 4) != 0)
                write_reg(tcpg_pkg::REG_FRAME_WIDTH, pick_width());
            if (ph == 0 || $urandom_range(0, 4) != 0)
                write_reg(tcpg_pkg::REG_FRAME_HEIGHT, pick_height());
            if (ph == 0 || $urandom_range(0, 99) < 40)
                restart_q.push_back(1'b1);
            for (n = 0; n < 60; n++)
                restart_q.push_back($urandom_range(0, 99) < 2);
            if (ph == 7)
                hold_asks = hold_asks + 1;
            drain();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tcpg_pkg.sv
rtl/tcpg_cfg.sv
rtl/tcpg_core.sv
rtl/tcpg_out.sv
rtl/test_card_pattern_generator_unit.sv
dv/tb.sv
